>>> design/jet_pkg.sv
`timescale 1ns / 1ps

package jet_pkg;

    // fixed-point format of the iterates
    localparam int unsigned FRAC_BITS = 27;

    // coordinate mapping: column offset 1.6 and row offset 0.9 in q4.27
    localparam logic signed [31:0] COL_OFFSET = 32'sd214748365;
    localparam logic signed [31:0] ROW_OFFSET = 32'sd120795955;

    // escape radius squared, 4.0 in q4.27, on the widened square sum
    localparam logic [36:0] ESCAPE_LIMIT = 37'(64'd4 << FRAC_BITS);

    // coordinate divider sizes
    localparam int unsigned DIV_DVD_W = 43;
    localparam int unsigned DIV_Q_W   = 29;
    localparam int unsigned DIV_D_W   = 16;
    localparam int unsigned DIV_CNT_W = 5;

    // register reset values
    localparam logic [12:0]        WIDTH_RESET  = 13'd1024;
    localparam logic [12:0]        HEIGHT_RESET = 13'd512;
    localparam logic signed [31:0] C_REAL_RESET = -32'sd106031005;
    localparam logic signed [31:0] C_IMAG_RESET = 32'sd20132659;

    // colour used when the budget runs out
    localparam logic [23:0] TRAPPED_COLOUR = {8'd200, 8'd100, 8'd100};

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_C_REAL,
        CFG_C_IMAG
    } cfg_index_t;

    typedef struct packed {
        logic [11:0] x_pos;
        logic [11:0] y_pos;
    } pixel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] remaining_count;
        logic       invalid;
    } colour_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCREEN,
        ST_DIV_COL,
        ST_DIV_ROW,
        ST_MUL,
        ST_UPD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_row;
        logic take_col;
        logic take_row;
        logic mul;
        logic step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic invalid;
        logic div_done;
        logic escape;
    } status_t;

    function automatic logic signed [31:0] sat32(logic signed [38:0] v);
        logic signed [31:0] r;
        if (v > 39'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -39'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // v * f^times, elaboration only
    function automatic logic [191:0] big_pow(logic [191:0] v, int unsigned f,
                                             int unsigned times);
        logic [191:0] r;
        r = v;
        for (int t = 0; t < 32; t++)
        begin
            if (t < times)
            begin
                r = r * 192'(f);
            end
        end
        return r;
    endfunction

    // floor(scale * (n/m)^(p/q)) by bisection on exact integers
    function automatic int unsigned pow_floor(int unsigned n, int unsigned m,
                                              int unsigned scale, int unsigned p,
                                              int unsigned q);
        logic [191:0] rhs;
        logic [191:0] lhs;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        rhs = big_pow(big_pow(192'd1, scale, q), n, p);
        lo  = 0;
        hi  = scale;
        for (int k = 0; k < 12; k++)
        begin
            if (lo < hi)
            begin
                mid = (lo + hi + 1) >> 1;
                lhs = big_pow(big_pow(192'd1, mid, q), m, p);
                if (lhs <= rhs)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 1;
                end
            end
        end
        return lo;
    endfunction

    // one colour table entry {red, green, blue} for a remaining count n of m
    function automatic logic [23:0] colour_entry(int unsigned n, int unsigned m);
        int unsigned       kr;
        int unsigned       kg;
        longint unsigned   m3;
        longint unsigned   n3;
        longint unsigned   rhs;
        int unsigned       lo;
        int unsigned       hi;
        int unsigned       mid;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [23:0]       r;
        if (n == 0)
        begin
            r = TRAPPED_COLOUR;
        end
        else
        begin
            kr    = pow_floor(n, m, 500, 8, 5);
            kg    = pow_floor(n, m, 255, 3, 10);
            red   = 8'(8'd0 - 8'(kr));
            green = 8'(8'd0 - 8'(kg));
            m3    = longint'(m) * longint'(m) * longint'(m);
            n3    = longint'(n) * longint'(n) * longint'(n);
            rhs   = 64'd255 * (m3 - n3);
            lo    = 0;
            hi    = 255;
            for (int k = 0; k < 10; k++)
            begin
                if (lo < hi)
                begin
                    mid = (lo + hi + 1) >> 1;
                    if (longint'(mid) * m3 <= rhs)
                    begin
                        lo = mid;
                    end
                    else
                    begin
                        hi = mid - 1;
                    end
                end
            end
            blue = 8'(lo);
            r    = {red, green, blue};
        end
        return r;
    endfunction

endpackage

>>> design/jet_divider.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit a cycle
module jet_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [jet_pkg::DIV_DVD_W-1:0]     dividend,
    input  logic [jet_pkg::DIV_D_W-1:0]       divisor,
    output logic [jet_pkg::DIV_Q_W-1:0]       quotient,
    output logic                              done
);

    localparam int unsigned QW = jet_pkg::DIV_Q_W;
    localparam int unsigned DW = jet_pkg::DIV_D_W;

    logic [DW-1:0]                    rem_reg,     rem_next;
    logic [QW-1:0]                    shift_reg,   shift_next;
    logic [DW-1:0]                    divisor_reg, divisor_next;
    logic [jet_pkg::DIV_CNT_W-1:0]    count_reg,   count_next;
    logic [DW+1:0]                    diff;
    logic                             fits;

    // quotient known to fit QW bits, so the top part starts below the divisor
    always_comb
    begin
        diff = {1'b0, rem_reg, shift_reg[QW-1]} - {2'b00, divisor_reg};
        fits = ~diff[DW+1];
        rem_next     = rem_reg;
        shift_next   = shift_reg;
        divisor_next = divisor_reg;
        count_next   = count_reg;
        if (start)
        begin
            rem_next     = DW'(dividend[jet_pkg::DIV_DVD_W-1:QW]);
            shift_next   = dividend[QW-1:0];
            divisor_next = divisor;
            count_next   = jet_pkg::DIV_CNT_W'(QW);
        end
        else if (count_reg != '0)
        begin
            rem_next   = fits ? diff[DW-1:0] : {rem_reg[DW-2:0], shift_reg[QW-1]};
            shift_next = {shift_reg[QW-2:0], fits};
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        shift_reg   <= shift_next;
        divisor_reg <= divisor_next;
    end

    assign quotient = shift_reg;
    assign done     = (count_reg == '0);

endmodule

>>> design/jet_colour_rom.sv
`timescale 1ns / 1ps

// colour table indexed by remaining count, entry 0 is the trapped colour
module jet_colour_rom #(
    parameter int unsigned ITER_LIMIT = 300
) (
    input  logic                               clk,
    input  logic [$clog2(ITER_LIMIT+1)-1:0]    addr,
    output logic [23:0]                        data
);

    localparam int unsigned DEPTH = ITER_LIMIT + 1;

    logic [23:0] rom_w [DEPTH];
    logic [23:0] data_reg, data_next;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_entry
        localparam logic [23:0] ENTRY = jet_pkg::colour_entry(i, ITER_LIMIT);
        assign rom_w[i] = ENTRY;
    end

    assign data_next = rom_w[addr];

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> design/jet_datapath.sv
`timescale 1ns / 1ps

module jet_datapath #(
    parameter int unsigned ITER_LIMIT = 300
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  jet_pkg::pixel_t     pixel,
    input  jet_pkg::cmd_t       cmd,
    output jet_pkg::status_t    status,
    output jet_pkg::colour_t    colour
);

    localparam int unsigned NW = $clog2(ITER_LIMIT + 1);

    // configuration
    logic [12:0]        width_reg,  width_next;
    logic [12:0]        height_reg, height_next;
    logic signed [31:0] c_real_reg, c_real_next;
    logic signed [31:0] c_imag_reg, c_imag_next;

    // pixel and iterates
    logic [11:0]        x_reg, y_reg;
    logic               invalid_reg, invalid_next;
    logic signed [31:0] a_reg, a_next;
    logic signed [31:0] b_reg, b_next;
    logic [35:0]        sa_reg, sb_reg;
    logic signed [37:0] ab_reg;
    logic [NW-1:0]      n_reg, n_next;
    jet_pkg::colour_t   colour_reg, colour_next;

    logic signed [63:0] aa, bb, ab;
    logic [36:0]        mag;
    logic signed [38:0] na_full, nb_full;
    logic [15:0]        nine_y;
    logic [jet_pkg::DIV_DVD_W-1:0] dividend;
    logic [jet_pkg::DIV_D_W-1:0]   divisor;
    logic [jet_pkg::DIV_Q_W-1:0]   quotient;
    logic signed [31:0]            mapped;
    logic                          div_done;
    logic [23:0]                   rom_data;
    logic [NW+8:0]                 n_ext;

    // configuration writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        c_real_next = c_real_reg;
        c_imag_next = c_imag_reg;
        if (cfg_write)
        begin
            case (jet_pkg::cfg_index_t'(cfg_index))
                jet_pkg::CFG_IMAGE_WIDTH:  width_next  = cfg_data[12:0];
                jet_pkg::CFG_IMAGE_HEIGHT: height_next = cfg_data[12:0];
                jet_pkg::CFG_C_REAL:       c_real_next = $signed(cfg_data);
                jet_pkg::CFG_C_IMAG:       c_imag_next = $signed(cfg_data);
                default:                   width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= jet_pkg::WIDTH_RESET;
            height_reg <= jet_pkg::HEIGHT_RESET;
            c_real_reg <= jet_pkg::C_REAL_RESET;
            c_imag_reg <= jet_pkg::C_IMAG_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            c_real_reg <= c_real_next;
            c_imag_reg <= c_imag_next;
        end
    end

    // coordinate division: column x*2^31 / 5w, row 9y*2^27 / 5h
    assign nine_y = 16'({y_reg, 3'b000}) + 16'(y_reg);

    always_comb
    begin
        if (cmd.div_row)
        begin
            dividend = {nine_y, 27'd0};
            divisor  = 16'({height_reg, 2'b00}) + 16'(height_reg);
        end
        else
        begin
            dividend = {x_reg, 31'd0};
            divisor  = 16'({width_reg, 2'b00}) + 16'(width_reg);
        end
    end

    jet_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    assign mapped = $signed({3'b000, quotient});

    // products of the current iterate
    always_comb
    begin
        aa = 64'(a_reg) * 64'(a_reg);
        bb = 64'(b_reg) * 64'(b_reg);
        ab = 64'(a_reg) * 64'(b_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            sa_reg <= aa[62:27];
            sb_reg <= bb[62:27];
            ab_reg <= ab[63:26];
        end
    end

    // escape test and next iterate
    assign mag     = {1'b0, sa_reg} + {1'b0, sb_reg};
    assign na_full = $signed({3'b000, sa_reg}) - $signed({3'b000, sb_reg})
                     + 39'(c_real_reg);
    assign nb_full = 39'(ab_reg) + 39'(c_imag_reg);

    always_comb
    begin
        invalid_next = invalid_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        n_next       = n_reg;
        if (cmd.load)
        begin
            invalid_next = ({1'b0, pixel.x_pos} >= width_reg)
                           || ({1'b0, pixel.y_pos} >= height_reg);
            n_next       = NW'(ITER_LIMIT);
        end
        if (cmd.take_col)
        begin
            a_next = mapped - jet_pkg::COL_OFFSET;
        end
        if (cmd.take_row)
        begin
            b_next = mapped - jet_pkg::ROW_OFFSET;
        end
        if (cmd.step)
        begin
            a_next = jet_pkg::sat32(na_full);
            b_next = jet_pkg::sat32(nb_full);
            n_next = n_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invalid_reg <= 1'b0;
            n_reg       <= '0;
        end
        else
        begin
            invalid_reg <= invalid_next;
            n_reg       <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= pixel.x_pos;
            y_reg <= pixel.y_pos;
        end
        a_reg <= a_next;
        b_reg <= b_next;
    end

    // colour lookup on the remaining count
    jet_colour_rom #(
        .ITER_LIMIT (ITER_LIMIT)
    ) u_colour_rom (
        .clk  (clk),
        .addr (n_reg),
        .data (rom_data)
    );

    assign n_ext = (NW + 9)'(n_reg);

    always_comb
    begin
        colour_next = colour_reg;
        if (cmd.out_load)
        begin
            if (invalid_reg)
            begin
                colour_next = '{red: 8'd0, green: 8'd0, blue: 8'd0,
                                remaining_count: 9'd0, invalid: 1'b1};
            end
            else
            begin
                colour_next = '{red: rom_data[23:16], green: rom_data[15:8],
                                blue: rom_data[7:0], remaining_count: n_ext[8:0],
                                invalid: 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        colour_reg <= colour_next;
    end

    assign status.invalid  = invalid_reg;
    assign status.div_done = div_done;
    assign status.escape   = (mag >= jet_pkg::ESCAPE_LIMIT) || (n_reg == '0);
    assign colour          = colour_reg;

endmodule

>>> design/jet_ctrl.sv
`timescale 1ns / 1ps

module jet_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pixel_valid,
    output logic                pixel_stall,
    output logic                colour_valid,
    input  logic                colour_stall,
    input  jet_pkg::status_t    status,
    output jet_pkg::cmd_t       cmd
);

    jet_pkg::state_t state_reg, state_next;
    logic            valid_reg, valid_next;
    logic            out_free;

    assign out_free = ~valid_reg | ~colour_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            jet_pkg::ST_IDLE:
            begin
                if (pixel_valid)
                begin
                    state_next = jet_pkg::ST_SCREEN;
                end
            end
            jet_pkg::ST_SCREEN:
            begin
                state_next = status.invalid ? jet_pkg::ST_FINISH : jet_pkg::ST_DIV_COL;
            end
            jet_pkg::ST_DIV_COL:
            begin
                if (status.div_done)
                begin
                    state_next = jet_pkg::ST_DIV_ROW;
                end
            end
            jet_pkg::ST_DIV_ROW:
            begin
                if (status.div_done)
                begin
                    state_next = jet_pkg::ST_MUL;
                end
            end
            jet_pkg::ST_MUL:
            begin
                state_next = jet_pkg::ST_UPD;
            end
            jet_pkg::ST_UPD:
            begin
                state_next = status.escape ? jet_pkg::ST_FINISH : jet_pkg::ST_MUL;
            end
            jet_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = jet_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = jet_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd         = '0;
        pixel_stall = 1'b1;
        case (state_reg)
            jet_pkg::ST_IDLE:
            begin
                pixel_stall = 1'b0;
                cmd.load    = pixel_valid;
            end
            jet_pkg::ST_SCREEN:
            begin
                cmd.div_start = ~status.invalid;
            end
            jet_pkg::ST_DIV_COL:
            begin
                cmd.take_col  = status.div_done;
                cmd.div_start = status.div_done;
                cmd.div_row   = 1'b1;
            end
            jet_pkg::ST_DIV_ROW:
            begin
                cmd.take_row = status.div_done;
            end
            jet_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            jet_pkg::ST_UPD:
            begin
                cmd.step = ~status.escape;
            end
            jet_pkg::ST_FINISH:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign valid_next = cmd.out_load | (valid_reg & colour_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jet_pkg::ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign colour_valid = valid_reg;

endmodule

>>> design/julia_escape_time_pixel.sv
`timescale 1ns / 1ps

// julia-set escape-time colouring of one pixel per beat. a pixel (x_pos, y_pos)
// is mapped onto the window -1.6..1.6 by -0.9..0.9 of the complex plane in
// signed q4.27, using image_width and image_height as divisors, then z -> z^2 + c
// is iterated with c from c_real / c_imag until |z|^2 reaches 4 or ITER_LIMIT
// steps are spent. the result beat carries the colour chosen from the remaining
// count, the count itself, and invalid set (colour and count zero) when the pixel
// lies outside the configured image. one pixel is worked on at a time: an in-range
// pixel passes screening, two serial coordinate divisions and then an iteration
// loop of multiply and update states, running 0 to ITER_LIMIT iterations; an
// out-of-range pixel goes from screening straight to the finish state. the
// finished beat sits in an output register, so the next pixel is accepted while
// it waits to be taken. registers are to be written through the cfg port only
// while no pixel is in flight; the user must keep to this, the block itself does
// not enforce it. the colour table is built when the design is elaborated.
module julia_escape_time_pixel #(
    parameter int unsigned ITER_LIMIT = 300
) (
    input  logic                clk,
    input  logic                rst_n,

    // configuration writes
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,

    // pixel channel
    input  logic                pixel_valid,
    output logic                pixel_stall,
    input  jet_pkg::pixel_t     pixel,

    // colour channel
    output logic                colour_valid,
    input  logic                colour_stall,
    output jet_pkg::colour_t    colour
);

    jet_pkg::cmd_t    cmd;
    jet_pkg::status_t status;

    // sequencer: screening, divisions, iteration loop, result hand-off
    jet_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .colour_valid (colour_valid),
        .colour_stall (colour_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // registers, divider, multipliers, colour table and output register
    jet_datapath #(
        .ITER_LIMIT (ITER_LIMIT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .cmd       (cmd),
        .status    (status),
        .colour    (colour)
    );

endmodule
